// ----- src/assert_macros.svh -----
// Assertion helpers for the keyboard focus queue router.
// Both take a label, a clock, an active-low reset and a property or condition.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define KFQR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

`define KFQR_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define KFQR_ASSERT(lbl, clk, rst_n, prop)

`define KFQR_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- src/kfqr_pkg.sv -----
`default_nettype none

package kfqr_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned NUM_TASKS_DEF   = 2;

  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned EVENT_W  = 3;
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = 1;
  localparam int unsigned CMDQ_CNT_W = 2;

  localparam logic [7:0] SC_RELEASE_BIT = 8'h80;
  localparam logic [6:0] SC_ENTER       = 7'h1C;
  localparam logic [6:0] SC_BACKSPACE   = 7'h0E;
  localparam logic [6:0] SC_TAB         = 7'h0F;

  localparam logic [CHAR_W-1:0] ASCII_NEWLINE   = 7'h0A;
  localparam logic [CHAR_W-1:0] ASCII_BACKSPACE = 7'h08;

  typedef enum logic [EVENT_W-1:0] {
    EV_IGNORED = 3'd0,
    EV_QUEUED  = 3'd1,
    EV_DROPPED = 3'd2,
    EV_FOCUS   = 3'd3,
    EV_POPPED  = 3'd4,
    EV_EMPTY   = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    OP_IGNORE = 2'd0,
    OP_FOCUS  = 2'd1,
    OP_PUSH   = 2'd2,
    OP_POP    = 2'd3
  } op_e;

  // One classified transaction handed from the front end to the back end.
  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic              task_sel;
  } kfqr_cmd_t;

  // Set-1 make code to lower-case ASCII; zero means the code is not mapped.
  function automatic logic [CHAR_W-1:0] key_map(input logic [6:0] code);
    logic [CHAR_W-1:0] c;
    c = '0;
    unique case (code)
      7'h02: c = 7'h31;
      7'h03: c = 7'h32;
      7'h04: c = 7'h33;
      7'h05: c = 7'h34;
      7'h06: c = 7'h35;
      7'h07: c = 7'h36;
      7'h08: c = 7'h37;
      7'h09: c = 7'h38;
      7'h0A: c = 7'h39;
      7'h0B: c = 7'h30;
      7'h10: c = 7'h71;
      7'h11: c = 7'h77;
      7'h12: c = 7'h65;
      7'h13: c = 7'h72;
      7'h14: c = 7'h74;
      7'h15: c = 7'h79;
      7'h16: c = 7'h75;
      7'h17: c = 7'h69;
      7'h18: c = 7'h6F;
      7'h19: c = 7'h70;
      7'h1E: c = 7'h61;
      7'h1F: c = 7'h73;
      7'h20: c = 7'h64;
      7'h21: c = 7'h66;
      7'h22: c = 7'h67;
      7'h23: c = 7'h68;
      7'h24: c = 7'h6A;
      7'h25: c = 7'h6B;
      7'h26: c = 7'h6C;
      7'h2C: c = 7'h7A;
      7'h2D: c = 7'h78;
      7'h2E: c = 7'h63;
      7'h2F: c = 7'h76;
      7'h30: c = 7'h62;
      7'h31: c = 7'h6E;
      7'h32: c = 7'h6D;
      7'h39: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/kfqr_ram.sv -----
`default_nettype none

module kfqr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/kfqr_front.sv -----
`default_nettype none

module kfqr_front (
  input  wire logic              cmd_i,
  input  wire logic [7:0]        scancode_i,
  input  wire logic              task_req_i,
  output kfqr_pkg::kfqr_cmd_t    cmd_o
);
  import kfqr_pkg::*;

  logic [6:0]        code;
  logic              released;
  logic [CHAR_W-1:0] mapped;

  assign code     = scancode_i[6:0];
  assign released = (scancode_i & SC_RELEASE_BIT) != 8'h00;

  always_comb begin
    priority if (code == SC_ENTER) begin
      mapped = ASCII_NEWLINE;
    end else if (code == SC_BACKSPACE) begin
      mapped = ASCII_BACKSPACE;
    end else begin
      mapped = key_map(code);
    end
  end

  always_comb begin
    cmd_o.ch       = '0;
    cmd_o.task_sel = task_req_i;
    priority if (cmd_i) begin
      cmd_o.op = OP_POP;
    end else if (released) begin
      cmd_o.op = OP_IGNORE;
    end else if (code == SC_TAB) begin
      cmd_o.op = OP_FOCUS;
    end else if (mapped != '0) begin
      cmd_o.op = OP_PUSH;
      cmd_o.ch = mapped;
    end else begin
      cmd_o.op = OP_IGNORE;
    end
  end

endmodule

`default_nettype wire

// ----- src/kfqr_cmdq.sv -----
`default_nettype none

module kfqr_cmdq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire kfqr_pkg::kfqr_cmd_t entry_i,
  input  wire logic                pop_i,
  output kfqr_pkg::kfqr_cmd_t      entry_o,
  output logic                     empty_o,
  output logic                     full_o
);
  import kfqr_pkg::*;

  kfqr_cmd_t             slot_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign empty_o = count_q == '0;
  assign full_o  = count_q == CMDQ_CNT_W'(CMDQ_DEPTH);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/kfqr_back.sv -----
`default_nettype none

module kfqr_back #(
  parameter int unsigned QUEUE_DEPTH = kfqr_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned NUM_TASKS   = kfqr_pkg::NUM_TASKS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire kfqr_pkg::kfqr_cmd_t    cmd_i,
  output logic                        done_o,
  output logic [kfqr_pkg::EVENT_W-1:0] event_res_o,
  output logic [kfqr_pkg::CHAR_W-1:0]  data_o,
  output logic                        focus_o
);
  import kfqr_pkg::*;

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned TASK_W = $clog2(NUM_TASKS);
  localparam int unsigned ADDR_W = $clog2(NUM_TASKS * QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [TASK_W-1:0] TASK_LAST = TASK_W'(NUM_TASKS - 1);
  localparam logic [ADDR_W-1:0] QD_ADDR   = ADDR_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0]  head_q [NUM_TASKS];
  logic [PTR_W-1:0]  head_d [NUM_TASKS];
  logic [PTR_W-1:0]  tail_q [NUM_TASKS];
  logic [PTR_W-1:0]  tail_d [NUM_TASKS];
  logic [TASK_W-1:0] focus_q, focus_d;

  logic              done_q;
  event_e            event_q, event_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              from_ram_q, from_ram_d;
  logic              focus_res_q;

  logic [TASK_W-1:0] sel;
  logic [PTR_W-1:0]  hd, tl, hd_next, tl_next;
  logic [ADDR_W-1:0] addr;
  logic              we, re;
  logic [CHAR_W-1:0] rdata;

  assign sel     = (cmd_i.op == OP_POP) ? TASK_W'(cmd_i.task_sel) : focus_q;
  assign hd      = head_q[sel];
  assign tl      = tail_q[sel];
  assign hd_next = (hd == PTR_LAST) ? '0 : hd + 1'b1;
  assign tl_next = (tl == PTR_LAST) ? '0 : tl + 1'b1;
  // Pushes address the tail slot of the focused task, pops the head slot of the requested task.
  assign addr    = sel * QD_ADDR + ADDR_W'((cmd_i.op == OP_POP) ? hd : tl);

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    focus_d    = focus_q;
    event_d    = EV_IGNORED;
    char_d     = '0;
    from_ram_d = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    if (valid_i) begin
      unique case (cmd_i.op)
        OP_IGNORE: begin
          event_d = EV_IGNORED;
        end
        OP_FOCUS: begin
          focus_d = (focus_q == TASK_LAST) ? '0 : focus_q + 1'b1;
          event_d = EV_FOCUS;
        end
        OP_PUSH: begin
          char_d = cmd_i.ch;
          if (tl_next != hd) begin
            we          = 1'b1;
            tail_d[sel] = tl_next;
            event_d     = EV_QUEUED;
          end else begin
            event_d = EV_DROPPED;
          end
        end
        OP_POP: begin
          if (hd != tl) begin
            re          = 1'b1;
            head_d[sel] = hd_next;
            from_ram_d  = 1'b1;
            event_d     = EV_POPPED;
          end else begin
            event_d = EV_EMPTY;
          end
        end
        default: event_d = EV_IGNORED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      focus_q <= '0;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      focus_q <= focus_d;
      done_q  <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      event_q     <= event_d;
      char_q      <= char_d;
      from_ram_q  <= from_ram_d;
      focus_res_q <= focus_d[0];
    end
  end

  kfqr_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (NUM_TASKS * QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (cmd_i.ch),
    .re_i    (re),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  assign done_o      = done_q;
  assign event_res_o = event_q;
  assign data_o      = from_ram_q ? rdata : char_q;
  assign focus_o     = focus_res_q;

endmodule

`default_nettype wire

// ----- src/keyboard_focus_queue_router_unit.sv -----
// Keyboard focus queue router.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low. cmd_i low delivers a set-1 scancode_i; cmd_i high asks to pop the
// oldest character of the task named by task_req_i.
// Result channel: done_o is high for exactly one cycle per transaction, with
// event_res_o, data_o and focus_o valid in that cycle. The receiver cannot
// stall it, so results must be taken when they appear.
// A taken transaction enters the command queue and its result is registered
// in the back end. One transaction per cycle is sustained; the front end
// classifies, a two-entry command queue decouples it from the back end, and
// the back end retires one transaction a cycle through the pointer update and
// one access of the character store (registered read for pops).
// The back end drains the command queue every cycle, so it never holds more
// than one entry and busy stays low in operation.
// Reset clears all queue pointers and gives focus to task zero. The character
// store is not cleared; only entries written by earlier pushes are ever read.
`default_nettype none
`include "assert_macros.svh"

module keyboard_focus_queue_router_unit #(
  parameter int unsigned QUEUE_DEPTH = kfqr_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned NUM_TASKS   = kfqr_pkg::NUM_TASKS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        cmd_i,
  input  wire logic [7:0]                  scancode_i,
  input  wire logic                        task_req_i,
  output logic                             done_o,
  output logic [kfqr_pkg::EVENT_W-1:0]     event_res_o,
  output logic [kfqr_pkg::CHAR_W-1:0]      data_o,
  output logic                             focus_o
);
  import kfqr_pkg::*;

  kfqr_cmd_t front_cmd;
  kfqr_cmd_t back_cmd;
  logic      q_empty;
  logic      q_full;
  logic      accept;
  logic      silent_ev;
  logic      char_ev;

  assign busy   = q_full;
  assign accept = start && !q_full;

  // Events that never carry a character, and those that always do.
  assign silent_ev = (event_res_o == EV_IGNORED) || (event_res_o == EV_FOCUS) ||
                     (event_res_o == EV_EMPTY);
  assign char_ev   = (event_res_o == EV_POPPED) || (event_res_o == EV_QUEUED) ||
                     (event_res_o == EV_DROPPED);

  kfqr_front u_front (
    .cmd_i      (cmd_i),
    .scancode_i (scancode_i),
    .task_req_i (task_req_i),
    .cmd_o      (front_cmd)
  );

  kfqr_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .entry_i (front_cmd),
    .pop_i   (!q_empty),
    .entry_o (back_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  kfqr_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_TASKS   (NUM_TASKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (!q_empty),
    .cmd_i       (back_cmd),
    .done_o      (done_o),
    .event_res_o (event_res_o),
    .data_o      (data_o),
    .focus_o     (focus_o)
  );

  // Every accepted transaction produces its result through the queue and back end.
  `KFQR_ASSERT(a_result_follows, clk_i, rst_ni, accept |-> ##2 done_o)
  `KFQR_NEVER(a_event_in_range, clk_i, rst_ni, done_o && (event_res_o > EV_EMPTY))
  `KFQR_ASSERT(a_no_data_on_silent_events, clk_i, rst_ni, (done_o && silent_ev) |-> (data_o == '0))
  `KFQR_NEVER(a_pop_gives_data, clk_i, rst_ni, done_o && char_ev && (data_o == '0))

endmodule

`default_nettype wire
